### hw/rtl/tldm_pkg.sv
// Shared constants and types for the two-level duty modulator.
// Holds register codes, field widths and the SplitMix64 mixing constants.
package tldm_pkg;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned AMP_W    = 24;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned SEED_W   = 32;
  localparam int unsigned EPOCH_W  = 48;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned MULT_W   = 25;
  localparam int unsigned LEVEL_W  = 40;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B  = 64'h94D049BB133111EB;

  localparam logic [MULT_W-1:0]  MULT_MAX  = 25'h0FFFFFF;
  localparam logic [MULT_W-1:0]  MULT_MIN  = 25'h1000000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 40'hFFFFFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_DUTY    = 3'd1,
    REG_AMP     = 3'd2,
    REG_BIN_LEN = 3'd3,
    REG_SEED    = 3'd4,
    REG_EPOCH   = 3'd5,
    REG_BASE    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_PERIODIC = 2'd0,
    MODE_RANDOM   = 2'd1,
    MODE_OFF      = 2'd2
  } mode_e;

endpackage

### hw/rtl/tldm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Divides an SW-bit magnitude by a 32-bit length; uses tldm_pkg.
module tldm_div_pipe import tldm_pkg::*; #(
  parameter int unsigned SW = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic             neg_i,
  input  logic [SW-1:0]    mag_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             valid_o,
  output logic             neg_o,
  output logic [SW-1:0]    quot_o,
  output logic [LEN_W-1:0] rem_o
);

  logic             vld_q [1:SW];
  logic             neg_q [1:SW];
  logic [SW-1:0]    n_q [1:SW];
  logic [LEN_W-1:0] r_q [1:SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic             v_in;
    logic             s_in;
    logic [SW-1:0]    n_in;
    logic [LEN_W-1:0] r_in;
    logic [LEN_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_in = valid_i;
      assign s_in = neg_i;
      assign n_in = mag_i;
      assign r_in = '0;
    end else begin : g_body
      assign v_in = vld_q[k];
      assign s_in = neg_q[k];
      assign n_in = n_q[k];
      assign r_in = r_q[k];
    end

    assign t  = {r_in, n_in[SW-1]};
    assign ge = t >= {1'b0, len_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1] <= s_in;
        n_q[k+1]   <= {n_in[SW-2:0], ge};
        r_q[k+1]   <= ge ? LEN_W'(t - {1'b0, len_i}) : t[LEN_W-1:0];
      end
    end
  end

  assign valid_o = vld_q[SW];
  assign neg_o   = neg_q[SW];
  assign quot_o  = n_q[SW];
  assign rem_o   = r_q[SW];

endmodule

### hw/rtl/tldm_lo_div.sv
// Low-state multiplier unit: ONE - round(a*d/(ONE-d)), saturated.
// Iterative radix-4 divider restarted on every register write; uses tldm_pkg.
module tldm_lo_div import tldm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AMP_W-1:0]  amp_i,
  input  logic [DUTY_W-1:0] duty_i,
  output logic [MULT_W-1:0] lo_mult_o
);

  localparam int unsigned NW    = 42;
  localparam int unsigned DW    = 25;
  localparam int unsigned STEPS = NW / 2;
  localparam logic [26:0] ONE   = 27'd1 << FRAC_BITS;

  logic signed [26:0] den_s;
  logic               den_pos;
  logic [DW-1:0]      den;
  logic [NW-1:0]      num;
  logic [NW-1:0]      n_q, n_d;
  logic [DW-1:0]      r_q, r_d;
  logic [4:0]         cnt_q;
  logic               load_q;
  logic signed [43:0] lo_full;

  assign den_s   = $signed(ONE) - $signed(27'(duty_i));
  assign den_pos = !den_s[26] && (den_s != '0);
  assign den     = den_s[DW-1:0];
  assign num     = NW'(40'(amp_i) * 40'(duty_i)) + NW'(den >> 1);

  always_comb begin
    logic [DW:0] t;
    n_d = n_q;
    r_d = r_q;
    for (int i = 0; i < 2; i++) begin
      t   = {r_d, n_d[NW-1]};
      n_d = {n_d[NW-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        r_d    = DW'(t - {1'b0, den});
        n_d[0] = 1'b1;
      end else begin
        r_d = t[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b1;
      cnt_q  <= '0;
    end else if (start_i) begin
      load_q <= 1'b1;
    end else if (load_q) begin
      load_q <= 1'b0;
      cnt_q  <= 5'(STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_q) begin
      n_q <= num;
      r_q <= '0;
    end else if (cnt_q != '0) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign lo_full = $signed(44'(ONE)) - $signed(44'(n_q));

  always_comb begin
    if (!den_pos || lo_full < -44'sd16777216) begin
      lo_mult_o = MULT_MIN;
    end else if (lo_full > 44'sd16777215) begin
      lo_mult_o = MULT_MAX;
    end else begin
      lo_mult_o = lo_full[MULT_W-1:0];
    end
  end

endmodule

### hw/rtl/two_level_duty_modulator_top.sv
// Two-level duty modulator: periodic or hashed per-bin high/low multiplier, or unity when off.
// Pipeline: time shift and magnitude registers, the divider, then floor fixup, hash, compare and scale.
// Throughput: one item per cycle while the output is not stalled; the divider runs one quotient bit per stage.
// A stalled output holding a valid item freezes the whole pipeline; nothing is lost or repeated.
// Reset: registers take their default values and the pipeline empties; the
// low-multiplier unit recomputes, overlapped with the first item.
module two_level_duty_modulator_top import tldm_pkg::*; #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_BITS-1:0] time_now_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MULT_W-1:0]    multiplier_o,
  output logic                 in_high_o,
  output logic [LEVEL_W-1:0]   total_level_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = (TIME_BITS < 64) ? TIME_BITS + 1 : 64;
  localparam logic [25:0] ONE = 26'd1 << FRAC_BITS;
  localparam logic [MULT_W-1:0] ONE_SAT = (FRAC_BITS >= 24) ? MULT_MAX : MULT_W'(ONE);

  logic [1:0]         mode_q;
  logic [DUTY_W-1:0]  duty_q;
  logic [AMP_W-1:0]   amp_q;
  logic [LEN_W-1:0]   len_cfg_q;
  logic [SEED_W-1:0]  seed_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [BASE_W-1:0]  base_q;

  logic               en;
  logic [LEN_W-1:0]   len;
  logic [63:0]        ep64, tm64;
  logic [25:0]        hi_sum;
  logic [MULT_W-1:0]  hi_mult, lo_mult;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_PERIODIC;
      duty_q    <= 16'd6554;
      amp_q     <= 24'd65536;
      len_cfg_q <= 32'd100000;
      seed_q    <= 32'd42;
      epoch_q   <= '0;
      base_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:    mode_q    <= cfg_data_i[1:0];
        REG_DUTY:    duty_q    <= cfg_data_i[DUTY_W-1:0];
        REG_AMP:     amp_q     <= cfg_data_i[AMP_W-1:0];
        REG_BIN_LEN: len_cfg_q <= cfg_data_i[LEN_W-1:0];
        REG_SEED:    seed_q    <= cfg_data_i[SEED_W-1:0];
        REG_EPOCH:   epoch_q   <= cfg_data_i[EPOCH_W-1:0];
        REG_BASE:    base_q    <= cfg_data_i[BASE_W-1:0];
        default:     ;
      endcase
    end
  end

  assign len     = (len_cfg_q == '0) ? 32'd1 : len_cfg_q;
  assign hi_sum  = 26'(amp_q) + ONE;
  assign hi_mult = (hi_sum > 26'h0FFFFFF) ? MULT_MAX : hi_sum[MULT_W-1:0];

  tldm_lo_div #(.FRAC_BITS(FRAC_BITS)) u_lo_div (
    .clk_i,
    .rst_ni,
    .start_i   (cfg_valid_i),
    .amp_i     (amp_q),
    .duty_i    (duty_q),
    .lo_mult_o (lo_mult)
  );

  if (TIME_BITS <= EPOCH_W) begin : g_ep_sext
    assign ep64 = 64'($signed(epoch_q[TIME_BITS-1:0]));
  end else begin : g_ep_zext
    assign ep64 = 64'(epoch_q);
  end
  assign tm64 = 64'($signed(time_now_i));

  // pipeline control
  logic [1:0]  pv_q;
  logic [11:1] vf_q;
  assign en          = !vf_q[11] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vf_q[11];

  logic [63:0]   shift_q;
  logic          neg1_q;
  logic [SW-1:0] mag1_q;
  logic          dv, dneg;
  logic [SW-1:0] dq;
  logic [LEN_W-1:0] dr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      vf_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[0], in_valid_i};
      vf_q <= {vf_q[10:1], dv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      shift_q <= tm64 - ep64;
      neg1_q  <= shift_q[63];
      mag1_q  <= shift_q[63] ? SW'(64'd0 - shift_q) : shift_q[SW-1:0];
    end
  end

  tldm_div_pipe #(.SW(SW)) u_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (pv_q[1]),
    .neg_i   (neg1_q),
    .mag_i   (mag1_q),
    .len_i   (len),
    .valid_o (dv),
    .neg_o   (dneg),
    .quot_o  (dq),
    .rem_o   (dr)
  );

  // floor fixup, hash, compare, scale
  logic [63:0]        q64, bin_q, t_q, y_q, z_q, h_q;
  logic [LEN_W-1:0]   rfix_q;
  logic [47:0]        dl_q;
  logic [63:0]        a0_q, b0_q;
  logic [31:0]        a1_q, a2_q, b1_q, b2_q;
  logic [8:2]         hp_q;
  logic               hr_q;
  logic [63:0]        x3, zs, ws;
  logic               high9_q, high10_q, high_q;
  logic [MULT_W-1:0]  mult9_q, mult10_q, mult_q;
  logic [55:0]        prod_q;
  logic [55:0]        lvl_sh;
  logic               high_sel;
  logic [MULT_W-1:0]  mult_sel;

  assign q64 = 64'(dq);
  assign x3  = t_q + GOLDEN;
  assign zs  = a0_q + {a1_q + a2_q, 32'd0};
  assign ws  = b0_q + {b1_q + b2_q, 32'd0};

  always_comb begin
    unique case (mode_q)
      MODE_PERIODIC: begin
        high_sel = hp_q[8];
        mult_sel = hp_q[8] ? hi_mult : lo_mult;
      end
      MODE_RANDOM: begin
        high_sel = hr_q;
        mult_sel = hr_q ? hi_mult : lo_mult;
      end
      default: begin
        high_sel = 1'b0;
        mult_sel = ONE_SAT;
      end
    endcase
  end

  assign lvl_sh = prod_q >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // f1
      bin_q  <= !dneg ? q64 : ((dr != '0) ? ~q64 : 64'd0 - q64);
      rfix_q <= (dneg && dr != '0) ? len - dr : dr;
      dl_q   <= 48'(duty_q) * 48'(len);
      // f2
      t_q     <= 64'(seed_q) ^ (bin_q + GOLDEN);
      hp_q[2] <= (64'(rfix_q) << FRAC_BITS) < 64'(dl_q);
      // f3
      y_q     <= x3 ^ (x3 >> 30);
      hp_q[3] <= hp_q[2];
      // f4
      a0_q    <= 64'(y_q[31:0]) * 64'(MIX_A[31:0]);
      a1_q    <= 32'(y_q[63:32] * MIX_A[31:0]);
      a2_q    <= 32'(y_q[31:0] * MIX_A[63:32]);
      hp_q[4] <= hp_q[3];
      // f5
      z_q     <= zs ^ (zs >> 27);
      hp_q[5] <= hp_q[4];
      // f6
      b0_q    <= 64'(z_q[31:0]) * 64'(MIX_B[31:0]);
      b1_q    <= 32'(z_q[63:32] * MIX_B[31:0]);
      b2_q    <= 32'(z_q[31:0] * MIX_B[63:32]);
      hp_q[6] <= hp_q[5];
      // f7
      h_q     <= ws ^ (ws >> 31);
      hp_q[7] <= hp_q[6];
      // f8
      hr_q    <= {11'd0, h_q[63:11]} < (64'(duty_q) << (53 - FRAC_BITS));
      hp_q[8] <= hp_q[7];
      // f9
      high9_q <= high_sel;
      mult9_q <= mult_sel;
      // f10
      high10_q <= high9_q;
      mult10_q <= mult9_q;
      prod_q   <= (!mult9_q[MULT_W-1] && mult9_q != '0)
                  ? 56'(base_q) * 56'(mult9_q[MULT_W-2:0]) : 56'd0;
      // f11
      high_q        <= high10_q;
      mult_q        <= mult10_q;
      total_level_o <= (lvl_sh > 56'(LEVEL_MAX)) ? LEVEL_MAX : lvl_sh[LEVEL_W-1:0];
    end
  end

  assign multiplier_o = mult_q;
  assign in_high_o    = high_q;

endmodule
